@@ rtl/core/ntcat_pkg.sv @@
// Shared constants for the NTC thermistor temperature converter.
// Used by the interfaces, the log2 unit, the top level and the checker.
// No dependencies.
package ntcat_pkg;

    // Default converter sample width.
    localparam int ADC_WIDTH_DEF = 12;

    // Result field width.
    localparam int TEMP_W = 15;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RAW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RAW = 1'b1;

    // Register reset values.
    localparam int MIN_RAW_RST = 100;
    localparam int MAX_RAW_RST = 4000;

    // Divider network and thermistor constants.
    localparam int FIXED_R_OHMS = 9970;
    localparam int NOMINAL_R_OHMS = 10000;
    localparam int T0_CENTI_K = 29815;
    localparam int KELVIN_OFFSET = 27315;
    localparam int TEMP_LOW = -5000;
    localparam int TEMP_HIGH = 15000;

    // ln(2) in Q30.
    localparam longint LN2_Q30 = 64'd744261118;

    // Width of the values fed to the log2 unit and of its Q16 result.
    localparam int LOG_IN_W = 31;
    localparam int LOG_FRAC = 16;
    localparam int LOG_W = 21;
    localparam int LOG_LAT = LOG_FRAC + 1;

    // Beta equation: T = NUM / (BETA*100*2^16 + T0*ln), all in fixed point.
    localparam longint DEN_BASE = 64'd25886720000;      // 3950*100*65536
    localparam longint NUM_CONST = 64'd771812556800000; // 29815*3950*100*65536
    localparam int D_W = 38;        // signed divisor sum
    localparam int DV_W = 36;       // positive divisor
    localparam int NUM_W = 50;      // dividend incl. rounding term
    localparam int QW = 20;         // quotient bits, one per divider stage
    localparam int REM_W = DV_W + 1;

endpackage

@@ rtl/core/ntcat_smp_if.sv @@
// Sample channel carrying one converter reading per transaction.
// Depends on ntcat_pkg for the default sample width.
interface ntcat_smp_if #(
    parameter int ADC_WIDTH = ntcat_pkg::ADC_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic [ADC_WIDTH-1:0] adc_raw;

    modport source(output valid, output adc_raw, input ready);
    modport sink(input valid, input adc_raw, output ready);
endinterface

@@ rtl/core/ntcat_res_if.sv @@
// Result channel carrying one temperature per transaction.
// Depends on ntcat_pkg for the result width.
interface ntcat_res_if;
    logic                               valid;
    logic                               ready;
    logic                               valid_res;
    logic signed [ntcat_pkg::TEMP_W-1:0] temperature_centi_c;

    modport source(output valid, output valid_res, output temperature_centi_c, input ready);
    modport sink(input valid, input valid_res, input temperature_centi_c, output ready);
endinterface

@@ rtl/core/ntc_adc_to_temperature.sv @@
// NTC thermistor converter top level: window check, log2 of divider terms,
// natural log, beta equation by a pipelined restoring divider, saturation.
// Depends on ntcat_pkg, ntcat_smp_if, ntcat_res_if and ntcat_log2.
//
// Takes one sample per clock unless the output stalls and returns one result
// per sample in order. The pipeline has one input stage, 17 log2 stages (one
// squarer per fraction bit), four stages for the log difference, ln(2)
// product, rounding and divisor, one dividend stage, 20 divider stages (one
// quotient bit each) and the output register. When the result is not taken
// the whole pipeline holds. Registers 0 (min_valid_raw) and 1 (max_valid_raw)
// are written on i_cfg_we and apply to samples accepted afterwards.
module ntc_adc_to_temperature #(
    parameter int ADC_WIDTH = ntcat_pkg::ADC_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ntcat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADC_WIDTH-1:0]            i_cfg_data,
    ntcat_smp_if.sink                       i_smp,
    ntcat_res_if.source                     o_res
);
    localparam int LL  = ntcat_pkg::LOG_LAT;
    localparam int QW  = ntcat_pkg::QW;
    localparam int LW  = ntcat_pkg::LOG_W;
    localparam int IW  = ntcat_pkg::LOG_IN_W;
    localparam int DW  = ntcat_pkg::D_W;
    localparam int VW  = ntcat_pkg::DV_W;
    localparam int RW  = ntcat_pkg::REM_W;
    localparam int NW  = ntcat_pkg::NUM_W;
    localparam int TW  = ntcat_pkg::TEMP_W;
    localparam logic [ADC_WIDTH-1:0] FS = '1;

    logic w_adv;

    // Configuration registers.
    logic [ADC_WIDTH-1:0] r_min_raw;
    logic [ADC_WIDTH-1:0] r_max_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_raw <= ADC_WIDTH'(ntcat_pkg::MIN_RAW_RST);
            r_max_raw <= ADC_WIDTH'(ntcat_pkg::MAX_RAW_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ntcat_pkg::CFG_MIN_RAW: r_min_raw <= i_cfg_data;
                ntcat_pkg::CFG_MAX_RAW: r_max_raw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Whole pipeline advances unless the output holds an untaken result.
    assign w_adv       = !o_res.valid || o_res.ready;
    assign i_smp.ready = w_adv;

    // Input stage: window check and divider terms.
    logic          r_p_v, r_p_ok;
    logic [IW-1:0] r_p_num, r_p_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (w_adv) begin
            r_p_v <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_ok  <= (i_smp.adc_raw > r_min_raw) && (i_smp.adc_raw < r_max_raw)
                       && (i_smp.adc_raw < FS);
            r_p_num <= IW'(i_smp.adc_raw) * IW'(ntcat_pkg::FIXED_R_OHMS);
            r_p_den <= IW'(FS - i_smp.adc_raw) * IW'(ntcat_pkg::NOMINAL_R_OHMS);
        end
    end

    // Logarithms of numerator and denominator.
    logic [LW-1:0] w_log_n, w_log_d;

    ntcat_log2 u_log_n (.i_clk(i_clk), .i_en(w_adv), .i_v(r_p_num), .o_log(w_log_n));
    ntcat_log2 u_log_d (.i_clk(i_clk), .i_en(w_adv), .i_v(r_p_den), .o_log(w_log_d));

    logic r_l_v  [0:LL-1];
    logic r_l_ok [0:LL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LL; i++) begin
                r_l_v[i] <= 1'b0;
            end
        end else if (w_adv) begin
            r_l_v[0] <= r_p_v;
            for (int i = 1; i < LL; i++) begin
                r_l_v[i] <= r_l_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_l_ok[0] <= r_p_ok;
            for (int i = 1; i < LL; i++) begin
                r_l_ok[i] <= r_l_ok[i-1];
            end
        end
    end

    // Divider pipeline; entry 0 is the dividend stage.
    logic          r_q_v   [0:QW];
    logic          r_q_ok  [0:QW];
    logic          r_q_bad [0:QW];
    logic [RW-1:0] r_q_rem [0:QW];
    logic [QW-1:0] r_q_low [0:QW];
    logic [VW-1:0] r_q_dv  [0:QW];
    logic [QW-1:0] r_q_q   [0:QW];

    // Stages A to E: log difference, ln(2) product, rounding, divisor, dividend.
    logic                 r_a_v, r_b_v, r_c_v, r_d_v;
    logic                 r_a_ok, r_b_ok, r_c_ok, r_d_ok;
    logic                 r_a_neg, r_b_neg;
    logic [LW:0]          r_a_mag;
    logic [LW+30:0]       r_b_prod;
    logic signed [LW+1:0] r_c_lnq;
    logic signed [DW-1:0] r_d_d;

    logic signed [LW:0]   w_l2;
    logic [LW+30:0]       w_rnd;
    logic [NW-1:0]        w_dvd;

    assign w_l2  = signed'({1'b0, w_log_n}) - signed'({1'b0, w_log_d});
    assign w_rnd = r_b_prod + (LW+31)'(64'd1 << 29);
    assign w_dvd = NW'(ntcat_pkg::NUM_CONST) + NW'(r_d_d[DW-1:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v    <= 1'b0;
            r_b_v    <= 1'b0;
            r_c_v    <= 1'b0;
            r_d_v    <= 1'b0;
            r_q_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_a_v    <= r_l_v[LL-1];
            r_b_v    <= r_a_v;
            r_c_v    <= r_b_v;
            r_d_v    <= r_c_v;
            r_q_v[0] <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_ok   <= r_l_ok[LL-1];
            r_a_neg  <= w_l2[LW];
            r_a_mag  <= w_l2[LW] ? (LW+1)'(-w_l2) : (LW+1)'(w_l2);

            r_b_ok   <= r_a_ok;
            r_b_neg  <= r_a_neg;
            r_b_prod <= (LW+31)'(r_a_mag) * (LW+31)'(ntcat_pkg::LN2_Q30);

            r_c_ok   <= r_b_ok;
            r_c_lnq  <= r_b_neg ? -signed'({1'b0, w_rnd[LW+30:30]})
                                :  signed'({1'b0, w_rnd[LW+30:30]});

            r_d_ok   <= r_c_ok;
            r_d_d    <= DW'(signed'(ntcat_pkg::DEN_BASE))
                        + DW'(r_c_lnq) * DW'(signed'(ntcat_pkg::T0_CENTI_K));

            r_q_ok[0]  <= r_d_ok;
            r_q_bad[0] <= (r_d_d <= 0);
            r_q_rem[0] <= RW'(w_dvd[NW-1:QW]);
            r_q_low[0] <= w_dvd[QW-1:0];
            r_q_dv[0]  <= VW'(r_d_d);
            r_q_q[0]   <= '0;
        end
    end

    // Restoring divider, one quotient bit per stage.
    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [RW-1:0] w_sh;
        logic          w_ge;
        assign w_sh = {r_q_rem[j][RW-2:0], r_q_low[j][QW-1]};
        assign w_ge = (w_sh >= RW'(r_q_dv[j]));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_v[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_q_v[j+1] <= r_q_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_q_ok[j+1]  <= r_q_ok[j];
                r_q_bad[j+1] <= r_q_bad[j];
                r_q_dv[j+1]  <= r_q_dv[j];
                r_q_low[j+1] <= r_q_low[j] << 1;
                r_q_rem[j+1] <= w_ge ? (w_sh - RW'(r_q_dv[j])) : w_sh;
                r_q_q[j+1]   <= {r_q_q[j][QW-2:0], w_ge};
            end
        end
    end

    // Output register: Kelvin offset, saturation, invalid samples read as zero.
    logic signed [QW+1:0] w_t;
    logic signed [TW-1:0] w_sat;
    logic                 r_o_v, r_o_ok;
    logic signed [TW-1:0] r_o_t;

    assign w_t = signed'({2'b00, r_q_q[QW]}) - (QW+2)'(ntcat_pkg::KELVIN_OFFSET);

    always_comb begin
        priority if (r_q_bad[QW]) begin
            w_sat = TW'(ntcat_pkg::TEMP_HIGH);
        end else if (w_t < (QW+2)'(ntcat_pkg::TEMP_LOW)) begin
            w_sat = TW'(ntcat_pkg::TEMP_LOW);
        end else if (w_t > (QW+2)'(ntcat_pkg::TEMP_HIGH)) begin
            w_sat = TW'(ntcat_pkg::TEMP_HIGH);
        end else begin
            w_sat = TW'(w_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_adv) begin
            r_o_v <= r_q_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_ok <= r_q_ok[QW];
            r_o_t  <= r_q_ok[QW] ? w_sat : '0;
        end
    end

    assign o_res.valid               = r_o_v;
    assign o_res.valid_res           = r_o_ok;
    assign o_res.temperature_centi_c = r_o_t;
endmodule

@@ rtl/core/ntcat_log2.sv @@
// Pipelined base-2 logarithm in Q16: normalize, then one squaring per fraction bit.
// Depends on ntcat_pkg.
module ntcat_log2 (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [ntcat_pkg::LOG_IN_W-1:0] i_v,
    output logic [ntcat_pkg::LOG_W-1:0]    o_log
);
    localparam int IW = ntcat_pkg::LOG_IN_W;
    localparam int FB = ntcat_pkg::LOG_FRAC;
    localparam int EW = ntcat_pkg::LOG_W - FB;

    logic [EW-1:0]              w_e;
    logic [IW-1:0]              w_m;
    logic [IW-1:0]              r_m   [0:FB];
    logic [ntcat_pkg::LOG_W-1:0] r_res [0:FB];

    // Leading-one position gives the integer part.
    always_comb begin
        w_e = '0;
        for (int b = 1; b < IW; b++) begin
            if (i_v[b]) begin
                w_e = EW'(b);
            end
        end
        w_m = i_v << (EW'(IW - 1) - w_e);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]   <= w_m;
            r_res[0] <= {w_e, FB'(0)};
        end
    end

    // Each stage squares the mantissa and takes one fraction bit.
    for (genvar k = 0; k < FB; k++) begin : g_sq
        logic [2*IW-1:0] w_sq;
        logic [IW:0]     w_t;
        assign w_sq = (2*IW)'(r_m[k]) * (2*IW)'(r_m[k]);
        assign w_t  = w_sq[2*IW-1:IW-1];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_t[IW]) begin
                    r_m[k+1]   <= w_t[IW:1];
                    r_res[k+1] <= r_res[k] | (ntcat_pkg::LOG_W'(1) << (FB - 1 - k));
                end else begin
                    r_m[k+1]   <= w_t[IW-1:0];
                    r_res[k+1] <= r_res[k];
                end
            end
        end
    end

    assign o_log = r_res[FB];
endmodule

@@ rtl/core/ntcat_chk.sv @@
// Port-level checker for the NTC converter, bound to the top level.
// Depends on ntcat_pkg and ntc_adc_to_temperature.
module ntcat_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_valid_res,
    input logic signed [ntcat_pkg::TEMP_W-1:0] i_temp
);
    // A rejected sample always reads as zero degrees.
    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_valid_res |-> i_temp == '0)
        else $error("invalid sample with nonzero temperature");

    // Results stay inside the saturation range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_valid_res |->
            i_temp >= ntcat_pkg::TEMP_W'(ntcat_pkg::TEMP_LOW)
            && i_temp <= ntcat_pkg::TEMP_W'(ntcat_pkg::TEMP_HIGH))
        else $error("temperature out of range");

    // No result appears right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

    // A stalled transaction keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_temp) && $stable(i_valid_res))
        else $error("stalled result changed");
endmodule

bind ntc_adc_to_temperature ntcat_chk u_ntcat_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_valid_res (o_res.valid_res),
    .i_temp      (o_res.temperature_centi_c)
);
